/* hdl/softmax_expectation_argmax_assert.svh */
// assertion macros for the softmax expectation block
// expects i_clk and i_rst_n in the scope of each use
`ifndef SOFTMAX_EXPECTATION_ARGMAX_ASSERT_SVH
`define SOFTMAX_EXPECTATION_ARGMAX_ASSERT_SVH

// condition implies consequence in the same cycle
`define SEA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sea assertion failed");

// condition implies consequence in the next cycle
`define SEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sea assertion failed");

`endif

/* hdl/sea_pkg.sv */
// shared types, widths and the exp table function for the softmax expectation block
// no dependencies
`default_nettype none

package sea_pkg;

    localparam int MAX_CHANNELS_DEF    = 256;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    localparam int LOGIT_W  = 16;
    localparam int CNT_W    = 9;
    localparam int BEST_W   = 8;
    localparam int EXPECT_W = 17;
    localparam int EXP_W    = 48;
    localparam int ESUM_W   = 56;
    localparam int WSUM_W   = 64;
    localparam int DIV_W    = 72;
    localparam int STEP_W   = 5;

    localparam logic [CNT_W-1:0] CNT_RESET = 9'd201;
    localparam logic [CNT_W-1:0] CNT_MIN   = 9'd2;

    localparam logic signed [LOGIT_W-1:0] EXP_LO = -16'sd16384;
    localparam logic signed [LOGIT_W-1:0] EXP_HI = 16'sd16383;

    localparam logic [EXPECT_W-1:0] EXPECT_SAT = 17'h1FFFF;
    localparam logic [STEP_W-1:0]   DIV_LAST   = STEP_W'(EXPECT_W - 1);

    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic in_fire;
        logic load_div;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_item;
    } t_dp_stat;

    // exp(-16 + u / 2^32) in q24.24, u already scaled by the table depth
    function automatic logic [EXP_W-1:0] exp_entry(input logic [63:0] u);
        logic [63:0] b;
        logic [63:0] nq;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] e;
        int          s;
        b  = u + 64'd24 * LN2_Q32 - (64'd16 << 32);
        nq = b / LN2_Q32;
        r  = b - nq * LN2_Q32;
        term = ONE_Q32;
        e    = term;
        term = ((term * r) >> 32) / 64'd1;  e = e + term;
        term = ((term * r) >> 32) / 64'd2;  e = e + term;
        term = ((term * r) >> 32) / 64'd3;  e = e + term;
        term = ((term * r) >> 32) / 64'd4;  e = e + term;
        term = ((term * r) >> 32) / 64'd5;  e = e + term;
        term = ((term * r) >> 32) / 64'd6;  e = e + term;
        term = ((term * r) >> 32) / 64'd7;  e = e + term;
        term = ((term * r) >> 32) / 64'd8;  e = e + term;
        term = ((term * r) >> 32) / 64'd9;  e = e + term;
        term = ((term * r) >> 32) / 64'd10; e = e + term;
        term = ((term * r) >> 32) / 64'd11; e = e + term;
        term = ((term * r) >> 32) / 64'd12; e = e + term;
        s = int'(nq) - 32;
        if (s >= 0) begin
            exp_entry = EXP_W'(e << s);
        end else begin
            exp_entry = EXP_W'(e >> (-s));
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/sea_ctrl.sv */
// controller for the softmax expectation block: handshakes, divider sequencing
// depends on sea_pkg and softmax_expectation_argmax_assert.svh
`default_nettype none
`include "softmax_expectation_argmax_assert.svh"

module sea_ctrl
    import sea_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state              r_state, n_state;
    logic                r_fin;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                last_ok;
    logic                out_free;

    // a last channel may enter only when the divider can take it next cycle
    assign last_ok    = (r_state == ST_IDLE) && !r_fin;
    assign o_in_stall = i_stat.last_item && !last_ok;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.in_fire  = i_in_valid && !o_in_stall;
        o_cmd.load_div = r_fin;
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.out_load = (r_state == ST_DONE) && out_free;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (r_fin) begin
                    n_state = ST_DIV;
                    n_step  = '0;
                end
            end
            ST_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fin       <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fin       <= o_cmd.in_fire && i_stat.last_item;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SEA_ASSERT_NOW(a_load_when_idle, r_fin, r_state == ST_IDLE)
    `SEA_ASSERT_NOW(a_step_bound, r_state == ST_DIV, r_step <= DIV_LAST)
    `SEA_ASSERT_NOW(a_out_no_overwrite, o_cmd.out_load, !r_out_valid || !i_out_stall)
    `SEA_ASSERT_NEXT(a_fin_single, r_fin, !r_fin)

endmodule

`default_nettype wire

/* hdl/sea_dpath.sv */
// datapath for the softmax expectation block: argmax, exp table, sums, divider
// depends on sea_pkg
`default_nettype none

module sea_dpath
    import sea_pkg::*;
#(
    parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CNT_W-1:0]           i_channel_count,
    input  wire logic signed [LOGIT_W-1:0]  i_logit,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_stat                        o_stat,
    output logic [BEST_W-1:0]               o_best_class,
    output logic [EXPECT_W-1:0]             o_expected_position,
    output logic                            o_is_background
);

    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TAB_AW = $clog2(EXP_TABLE_DEPTH);
    localparam int PW     = 15 + TAB_AW + 1;
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_CHANNELS);
    localparam logic [PW-1:0]     DEPTH_P   = PW'(EXP_TABLE_DEPTH);
    localparam logic [TAB_AW:0]   DEPTH_I   = (TAB_AW + 1)'(EXP_TABLE_DEPTH);
    localparam logic [TAB_AW:0]   DEPTH_TOP = (TAB_AW + 1)'(EXP_TABLE_DEPTH - 1);

    // constant exp table
    logic [EXP_W-1:0] exp_tab [EXP_TABLE_DEPTH];

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
        localparam logic [63:0] U = (64'(g) << 37) / EXP_TABLE_DEPTH;
        assign exp_tab[g] = exp_entry(U);
    end

    logic [CNT_W-1:0]           r_cfg;
    logic [CNT_W-1:0]           cnt;
    logic [IDX_W-1:0]           r_idx;
    logic [CNT_W-1:0]           idx_n;
    logic                       last;
    logic signed [LOGIT_W-1:0]  r_best_val;
    logic [IDX_W-1:0]           r_best_idx;
    logic                       take;
    logic [IDX_W-1:0]           best_now;
    logic [IDX_W-1:0]           r_fin_best;
    logic                       r_fin_bg;

    logic signed [LOGIT_W-1:0]  xc;
    logic [LOGIT_W-1:0]         off;
    logic [PW-1:0]              prod;
    logic [TAB_AW:0]            tab_iw;
    logic [TAB_AW-1:0]          tab_i;

    logic                       r_add_vld;
    logic [EXP_W-1:0]           r_e;
    logic [CNT_W-1:0]           r_k;
    logic [EXP_W+CNT_W-1:0]     wprod;
    logic [ESUM_W-1:0]          r_esum;
    logic [WSUM_W-1:0]          r_wsum;

    logic [DIV_W-1:0]           r_rem;
    logic [DIV_W-1:0]           r_dvs;
    logic [EXPECT_W-1:0]        r_quo;
    logic                       r_sat;
    logic                       r_zero;
    logic                       ge;
    logic [EXPECT_W-1:0]        expect_val;

    // clamped channel count
    always_comb begin
        if (r_cfg < CNT_MIN) begin
            cnt = CNT_MIN;
        end else if (r_cfg > CNT_MAX) begin
            cnt = CNT_MAX;
        end else begin
            cnt = r_cfg;
        end
    end

    assign idx_n            = {{(CNT_W - IDX_W){1'b0}}, r_idx} + CNT_W'(1);
    assign last             = (idx_n >= cnt);
    assign o_stat.last_item = last;

    assign take     = (r_idx == '0) || (i_logit > r_best_val);
    assign best_now = take ? r_idx : r_best_idx;

    // exp lookup index
    always_comb begin
        if (i_logit < EXP_LO) begin
            xc = EXP_LO;
        end else if (i_logit > EXP_HI) begin
            xc = EXP_HI;
        end else begin
            xc = i_logit;
        end
        off    = xc - EXP_LO;
        prod   = {{(PW - 15){1'b0}}, off[14:0]} * DEPTH_P;
        tab_iw = prod[PW-1:15];
        if (tab_iw >= DEPTH_I) begin
            tab_iw = DEPTH_TOP;
        end
        tab_i = tab_iw[TAB_AW-1:0];
    end

    assign wprod = r_e * r_k;

    // divider step: one quotient bit per cycle
    assign ge = (r_rem >= r_dvs);

    always_comb begin
        if (r_zero) begin
            expect_val = '0;
        end else if (r_sat) begin
            expect_val = EXPECT_SAT;
        end else begin
            expect_val = r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= CNT_RESET;
            r_idx     <= '0;
            r_add_vld <= 1'b0;
            r_esum    <= '0;
            r_wsum    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_channel_count;
            end
            r_add_vld <= i_cmd.in_fire && !last;
            if (i_cmd.in_fire) begin
                r_idx <= last ? '0 : idx_n[IDX_W-1:0];
            end
            if (i_cmd.load_div) begin
                r_esum <= '0;
                r_wsum <= '0;
            end else if (r_add_vld) begin
                r_esum <= r_esum + {{(ESUM_W - EXP_W){1'b0}}, r_e};
                r_wsum <= r_wsum + {{(WSUM_W - EXP_W - CNT_W){1'b0}}, wprod};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_fire) begin
            r_best_val <= take ? i_logit : r_best_val;
            r_best_idx <= best_now;
            r_e        <= exp_tab[tab_i];
            r_k        <= idx_n;
            if (last) begin
                r_fin_best <= best_now;
                r_fin_bg   <= ({{(CNT_W - IDX_W){1'b0}}, best_now} == cnt - CNT_W'(1));
            end
        end
        if (i_cmd.load_div) begin
            r_rem  <= {r_wsum, 8'd0};
            r_dvs  <= {r_esum, 16'd0};
            r_quo  <= '0;
            r_sat  <= ({1'b0, r_wsum} >= {r_esum, 9'd0});
            r_zero <= (r_esum == '0) || r_fin_bg;
        end else if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[EXPECT_W-2:0], ge};
        end
        if (i_cmd.out_load) begin
            o_best_class        <= BEST_W'(r_fin_best);
            o_expected_position <= expect_val;
            o_is_background     <= r_fin_bg;
        end
    end

endmodule

`default_nettype wire

/* hdl/softmax_expectation_argmax.sv */
// softmax expectation with argmax, top level; depends on sea_pkg, sea_ctrl, sea_dpath
// throughput: one logit per cycle within a cell while o_in_stall is low; a cell's last
// channel stalls while a finished result sits stalled in the output register
// the result comes from a 17-step shift-subtract divider
// the divider overlaps the next cell; its last channel waits until the previous division
// is done and that result has moved into the output register
`default_nettype none

module softmax_expectation_argmax
    import sea_pkg::*;
#(
    parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    // reset: synchronous active-low; count returns to 201, cell sums and handshakes clear
    input  wire logic                      i_rst_n,
    // configuration write channel, always ready
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CNT_W-1:0]          i_channel_count,
    // logit request channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic signed [LOGIT_W-1:0] i_logit,
    // result request channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [BEST_W-1:0]              o_best_class,
    output logic [EXPECT_W-1:0]            o_expected_position,
    output logic                           o_is_background
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // the count register takes a write on any cycle
    assign o_cfg_ready = 1'b1;

    // controller: input stall, divider sequencing, output register valid
    sea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: channel counter, argmax, exp lookup, running sums and
    // the restoring divider that forms the q9.8 expectation
    sea_dpath #(
        .MAX_CHANNELS    (MAX_CHANNELS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_valid && o_cfg_ready),
        .i_channel_count     (i_channel_count),
        .i_logit             (i_logit),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_best_class        (o_best_class),
        .o_expected_position (o_expected_position),
        .o_is_background     (o_is_background)
    );

endmodule

`default_nettype wire
